// File: design/rab_pkg.sv
// rab_pkg: shared widths, stage structs, register indexes and the Q16.16 clamp
// for the ray/box slab test. No dependencies.
package rab_pkg;

	localparam int unsigned IN_W       = 24;
	localparam int unsigned CFG_W      = 23;
	localparam int unsigned T_W        = 32;
	localparam int unsigned Q_W        = 37;   // reciprocal magnitude, up to 2^36
	localparam int unsigned DIV_BITS   = 4;    // quotient bits per divider stage
	localparam int unsigned DIV_STAGES = 10;   // 40 quotient bits, top 3 always zero
	localparam int unsigned ONE_BIT    = 36;   // dividend is 2^36
	localparam int unsigned FRAC_DROP  = 20;
	localparam int unsigned LO_W       = 18;   // split point of the reciprocal
	localparam int unsigned AXIS_STG   = 3;
	localparam int unsigned RED_STG    = 2;
	localparam int unsigned N_STAGES   = 1 + DIV_STAGES + AXIS_STG + RED_STG;

	localparam logic [1:0] REG_HALF_X = 2'd0;
	localparam logic [1:0] REG_HALF_Y = 2'd1;
	localparam logic [1:0] REG_HALF_Z = 2'd2;

	localparam logic [1:0] NRM_ZERO = 2'b00;
	localparam logic [1:0] NRM_POS  = 2'b01;
	localparam logic [1:0] NRM_NEG  = 2'b11;

	typedef struct packed {
		logic [IN_W-1:0]        rem;
		logic [Q_W-1:0]         quo;
		logic [IN_W-1:0]        dmag;
		logic signed [IN_W-1:0] org;
		logic                   dneg;
		logic                   dzero;
	} div_t;

	typedef struct packed {
		logic signed [T_W-1:0] t1;
		logic signed [T_W-1:0] t2;
		logic                  dpos;
		logic                  dneg;
	} axis_res_t;

	function automatic logic signed [T_W-1:0] sat_t(input logic signed [63:0] v);
		logic signed [T_W-1:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[T_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: design/rab_div_stage.sv
// rab_div_stage: one registered slice of the restoring divider for 2^36 / |dir|.
// Retires DIV_BITS quotient bits per stage. Depends on rab_pkg.
module rab_div_stage #(
	parameter int unsigned FIRST_BIT = 39
) (
	input  logic          clk,
	input  logic          en,
	input  rab_pkg::div_t d_in,
	output rab_pkg::div_t d_s1
);

	rab_pkg::div_t nxt;

	always_comb begin
		logic [rab_pkg::IN_W:0] trial;
		logic                   qb;
		nxt = d_in;
		for (int k = 0; k < int'(rab_pkg::DIV_BITS); k++) begin
			trial = {nxt.rem, ((int'(FIRST_BIT) - k) == int'(rab_pkg::ONE_BIT))};
			if (trial >= {1'b0, nxt.dmag}) begin
				trial = trial - {1'b0, nxt.dmag};
				qb    = 1'b1;
			end else begin
				qb    = 1'b0;
			end
			nxt.rem = trial[rab_pkg::IN_W-1:0];
			nxt.quo = {nxt.quo[rab_pkg::Q_W-2:0], qb};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= nxt;
		end
	end

endmodule

// File: design/rab_axis.sv
// rab_axis: per-axis slab math: reciprocal clamp, split products, t1/t2 sums
// with floor shift and Q16.16 clamp. Three register stages. Depends on rab_pkg.
module rab_axis (
	input  logic                          clk,
	input  logic [rab_pkg::AXIS_STG-1:0]  en,
	input  rab_pkg::div_t                 src,
	input  logic [rab_pkg::CFG_W-1:0]     half,
	output rab_pkg::axis_res_t            res
);

	logic [rab_pkg::Q_W-1:0]  mq;
	logic [rab_pkg::IN_W-1:0] omag;

	always_comb begin
		if (src.dzero) begin
			mq = {1'b0, {(rab_pkg::Q_W-1){1'b1}}};
		end else if (src.dmag == rab_pkg::IN_W'(1)) begin
			mq = src.dneg ? {1'b1, {(rab_pkg::Q_W-1){1'b0}}}
			              : {1'b0, {(rab_pkg::Q_W-1){1'b1}}};
		end else begin
			mq = src.quo;
		end
		omag = src.org[rab_pkg::IN_W-1] ? (~src.org + 1'b1) : src.org;
	end

	// stage 1: partial products, each at most 19x24
	logic [41:0] plo_s1;
	logic [42:0] phi_s1;
	logic [40:0] klo_s1;
	logic [41:0] khi_s1;
	logic        nneg_s1, dpos_s1, dneg_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			plo_s1  <= mq[rab_pkg::LO_W-1:0] * omag;
			phi_s1  <= mq[rab_pkg::Q_W-1:rab_pkg::LO_W] * omag;
			klo_s1  <= mq[rab_pkg::LO_W-1:0] * half;
			khi_s1  <= mq[rab_pkg::Q_W-1:rab_pkg::LO_W] * half;
			nneg_s1 <= src.dneg ^ src.org[rab_pkg::IN_W-1];
			dpos_s1 <= !src.dneg && !src.dzero;
			dneg_s1 <= src.dneg;
		end
	end

	// stage 2: recombine, apply sign of n
	logic [63:0]        nmag, kmag;
	logic signed [63:0] n_s2, k_s2;
	logic               dpos_s2, dneg_s2;

	assign nmag = (64'(phi_s1) << rab_pkg::LO_W) + 64'(plo_s1);
	assign kmag = (64'(khi_s1) << rab_pkg::LO_W) + 64'(klo_s1);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s2    <= nneg_s1 ? -$signed(nmag) : $signed(nmag);
			k_s2    <= $signed(kmag);
			dpos_s2 <= dpos_s1;
			dneg_s2 <= dneg_s1;
		end
	end

	// stage 3: t1 = -n-k, t2 = -n+k, floor to Q16.16, clamp
	logic signed [63:0] s1v, s2v;

	assign s1v = (-n_s2 - k_s2) >>> rab_pkg::FRAC_DROP;
	assign s2v = (-n_s2 + k_s2) >>> rab_pkg::FRAC_DROP;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			res.t1   <= rab_pkg::sat_t(s1v);
			res.t2   <= rab_pkg::sat_t(s2v);
			res.dpos <= dpos_s2;
			res.dneg <= dneg_s2;
		end
	end

endmodule

// File: design/rab_reduce.sv
// rab_reduce: max of t1, min of t2, entry normal, then hit flag.
// Two register stages; the second is the output register. Depends on rab_pkg.
module rab_reduce (
	input  logic                         clk,
	input  logic [rab_pkg::RED_STG-1:0]  en,
	input  rab_pkg::axis_res_t           ax [3],
	output logic                         hit,
	output logic signed [rab_pkg::T_W-1:0] t_near,
	output logic signed [rab_pkg::T_W-1:0] t_far,
	output logic signed [1:0]            normal_x,
	output logic signed [1:0]            normal_y,
	output logic signed [1:0]            normal_z
);

	logic signed [rab_pkg::T_W-1:0] tn, tf;
	logic [1:0]                     nrm [3];

	always_comb begin
		tn = ax[0].t1;
		if (ax[1].t1 > tn) tn = ax[1].t1;
		if (ax[2].t1 > tn) tn = ax[2].t1;
		tf = ax[0].t2;
		if (ax[1].t2 < tf) tf = ax[1].t2;
		if (ax[2].t2 < tf) tf = ax[2].t2;
		for (int i = 0; i < 3; i++) begin
			nrm[i] = rab_pkg::NRM_ZERO;
			if (ax[i].t1 >= ax[(i + 1) % 3].t1 && ax[i].t1 >= ax[(i + 2) % 3].t1) begin
				if (ax[i].dpos) begin
					nrm[i] = rab_pkg::NRM_NEG;
				end else if (ax[i].dneg) begin
					nrm[i] = rab_pkg::NRM_POS;
				end
			end
		end
	end

	logic signed [rab_pkg::T_W-1:0] tn_s1, tf_s1;
	logic [1:0]                     nrm_s1 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			tn_s1  <= tn;
			tf_s1  <= tf;
			nrm_s1 <= nrm;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hit      <= !(tn_s1 > tf_s1);
			t_near   <= tn_s1;
			t_far    <= tf_s1;
			normal_x <= nrm_s1[0];
			normal_y <= nrm_s1[1];
			normal_z <= nrm_s1[2];
		end
	end

endmodule

// File: design/ray_aabb_slab_intersection.sv
// ray_aabb_slab_intersection: top level of the ray versus origin-centered box test.
// Depends on rab_pkg, rab_div_stage, rab_axis, rab_reduce.
//
// Usage
//   Input channel (in_valid/in_ready) carries one ray per beat: origin and
//   direction, signed Q8.16 per axis. Output channel (out_valid/out_ready)
//   carries one result beat per ray: hit, t_near, t_far (signed Q16.16,
//   clamped) and the entry normal (-1, 0, +1 per axis).
//   Config port: cfg_we with cfg_index 0..2 writes half_size_x/y/z (unsigned
//   Q7.16). Other indexes are dropped. Write only while the pipe is empty.
//   Each accepted input beat passes through 16 register stages: one input
//   register, ten divider stages (4 quotient bits each, 2^36/|dir|), three
//   per-axis product/sum stages, two reduce stages ending in the output reg.
//   Throughput is one ray per cycle while the output is not stalled; the divider slices set the depth.
//   Each stage has its own valid bit and holds while the next stage is full
//   and stalled, so bubbles squeeze out and in_ready stays high while any
//   stage is empty, even with a result waiting at the output.
//   Reset clears all valid bits and sets each half size to 1.0 (65536).
module ray_aabb_slab_intersection (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [rab_pkg::IN_W-1:0]  origin_x,
	input  logic signed [rab_pkg::IN_W-1:0]  origin_y,
	input  logic signed [rab_pkg::IN_W-1:0]  origin_z,
	input  logic signed [rab_pkg::IN_W-1:0]  dir_x,
	input  logic signed [rab_pkg::IN_W-1:0]  dir_y,
	input  logic signed [rab_pkg::IN_W-1:0]  dir_z,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic signed [rab_pkg::T_W-1:0]   t_near,
	output logic signed [rab_pkg::T_W-1:0]   t_far,
	output logic signed [1:0]                normal_x,
	output logic signed [1:0]                normal_y,
	output logic signed [1:0]                normal_z,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [rab_pkg::CFG_W-1:0]        cfg_data
);

	localparam int unsigned NS = rab_pkg::N_STAGES;
	localparam int unsigned AX0 = 1 + rab_pkg::DIV_STAGES;   // first axis stage
	localparam int unsigned RD0 = AX0 + rab_pkg::AXIS_STG;   // first reduce stage

	// config registers
	logic [rab_pkg::CFG_W-1:0] half_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) half_q[a] <= rab_pkg::CFG_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				rab_pkg::REG_HALF_X: half_q[0] <= cfg_data;
				rab_pkg::REG_HALF_Y: half_q[1] <= cfg_data;
				rab_pkg::REG_HALF_Z: half_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-stage valid and advance
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int i = NS - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < int'(NS); i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NS-1];

	// input register: |dir|, flags
	logic signed [rab_pkg::IN_W-1:0] org_in [3];
	logic signed [rab_pkg::IN_W-1:0] dir_in [3];
	rab_pkg::div_t                   in_s1  [3];

	assign org_in = '{origin_x, origin_y, origin_z};
	assign dir_in = '{dir_x, dir_y, dir_z};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int a = 0; a < 3; a++) begin
				in_s1[a].rem   <= '0;
				in_s1[a].quo   <= '0;
				in_s1[a].dmag  <= dir_in[a][rab_pkg::IN_W-1] ? (~dir_in[a] + 1'b1) : dir_in[a];
				in_s1[a].org   <= org_in[a];
				in_s1[a].dneg  <= dir_in[a][rab_pkg::IN_W-1];
				in_s1[a].dzero <= (dir_in[a] == '0);
			end
		end
	end

	rab_pkg::div_t      dv [3][rab_pkg::DIV_STAGES+1];
	rab_pkg::axis_res_t axr [3];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign dv[a][0] = in_s1[a];
		for (genvar j = 0; j < int'(rab_pkg::DIV_STAGES); j++) begin : g_div
			rab_div_stage #(
				.FIRST_BIT(rab_pkg::DIV_BITS * rab_pkg::DIV_STAGES - 1 - rab_pkg::DIV_BITS * j)
			) u_div (
				.clk  (clk),
				.en   (en[1+j]),
				.d_in (dv[a][j]),
				.d_s1 (dv[a][j+1])
			);
		end
		rab_axis u_axis (
			.clk  (clk),
			.en   (en[AX0 +: rab_pkg::AXIS_STG]),
			.src  (dv[a][rab_pkg::DIV_STAGES]),
			.half (half_q[a]),
			.res  (axr[a])
		);
	end

	rab_reduce u_reduce (
		.clk      (clk),
		.en       (en[RD0 +: rab_pkg::RED_STG]),
		.ax       (axr),
		.hit      (hit),
		.t_near   (t_near),
		.t_far    (t_far),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z)
	);

	// checks
	a_hit_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (t_near <= t_far)))
		else $error("hit flag disagrees with t_near/t_far");

	a_nrm_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (normal_x != 2'b10 && normal_y != 2'b10 && normal_z != 2'b10))
		else $error("normal component out of range");

	a_vld_flow: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_q[NS-2]))
		else $error("output beat appeared without an upstream beat");

endmodule
